// ===== src/rtpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpp_pkg
// Shared types and constants of the PCMU RTP packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpp_pkg;

   localparam logic [7:0]  HDR_VERSION_BYTE = 8'h80;
   localparam logic [7:0]  HDR_PTYPE_BYTE   = 8'h00;
   localparam logic [31:0] SSRC_RESET       = 32'd1234567890;
   localparam logic [15:0] SEQ_RESET        = 16'd1;
   localparam logic [12:0] LIMIT_RESET      = 13'd160;
   localparam logic [12:0] SAMPLES_PER_SEC  = 13'd8000;
   localparam logic [12:0] MS_PER_SEC       = 13'd1000;
   localparam logic [9:0]  MS_MIN           = 10'd1;
   localparam logic [9:0]  MS_MAX           = 10'd1000;
   localparam logic [3:0]  DATA_IDX         = 4'd12;
   localparam logic [3:0]  DIV_STEPS        = 4'd13;

   typedef enum logic [0:0] {
      CSR_PAYLOAD_TIME = 1'b0,
      CSR_SSRC         = 1'b1
   } csr_index_type;

   // one accepted byte, classified, with the header fields it needs
   typedef struct packed {
      logic [7:0]  sample_byte;
      logic        closing;
      logic        opens;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] ssrc;
   } pkt_item_type;

   typedef struct packed {
      logic        start;
      logic [12:0] dividend;
      logic [9:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [12:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== src/rtpp_req_if.sv =====
// ----------------------------------------------------------------------------
// rtpp_req_if
// Audio byte channel: valid/ready with one mu-law byte and a final mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_byte;
   logic       final_byte;

   modport source (output valid, output sample_byte, output final_byte, input ready);
   modport sink   (input valid, input sample_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== src/rtpp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rtpp_rsp_if
// Packet byte channel: valid/ready with one packet byte and an end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       packet_end;

   modport source (output valid, output packet_byte, output packet_end, input ready);
   modport sink   (input valid, input packet_byte, input packet_end, output ready);
endinterface

`default_nettype wire

// ===== src/rtp_pcmu_packetizer.sv =====
// an accepted byte is written into the queue; its first packet byte is then loaded into the output register
// throughput: one packet byte per cycle from the output stage while rsp.ready is high and
//   the queue holds a byte; a byte that opens a packet is sent after its twelve header bytes
// a packet duration write holds req.ready low through two 13-step divides
// reset is synchronous: sequence 1, timestamp 0, empty packet, 20 ms, default ssrc
// ----------------------------------------------------------------------------
// rtp_pcmu_packetizer
// Frames mu-law audio bytes into RTP packets, header bytes then payload.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_pcmu_packetizer
   import rtpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   rtpp_req_if.sink         req,
   rtpp_rsp_if.source       rsp,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic         push;
   logic         pop;
   logic         queue_full;
   logic         queue_not_empty;
   pkt_item_type push_item;
   pkt_item_type head;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   rtpp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rtpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item),
      .div_req    (div_req),
      .div_rsp    (div_rsp)
   );

   rtpp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   rtpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .head      (head),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ===== src/rtpp_div.sv =====
// ----------------------------------------------------------------------------
// rtpp_div
// Restoring divider, one quotient bit per cycle, 13-bit by 10-bit unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpp_div
   import rtpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic        busy_ff,    busy_in;
   logic        done_ff,    done_in;
   logic [3:0]  count_ff,   count_in;
   logic [9:0]  rem_ff,     rem_in;
   logic [12:0] quo_ff,     quo_in;
   logic [9:0]  divisor_ff, divisor_in;

   logic [10:0] shifted;
   logic [10:0] diff;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[12]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_STEPS;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[9:0] : shifted[9:0];
         quo_in   = {quo_ff[11:0], fits};
         count_in = count_ff - 4'd1;
         if (count_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/rtpp_front.sv =====
// ----------------------------------------------------------------------------
// rtpp_front
// Accepts audio bytes, tracks packet fill, sequence and timestamp, and
// classifies each byte (opens / closes a packet). Holds the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpp_front
   import rtpp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   rtpp_req_if.sink           req,
   input  wire logic          csr_we,
   input  wire logic [0:0]    csr_index,
   input  wire logic [31:0]   csr_wdata,
   input  wire logic          queue_full,
   output logic               push,
   output pkt_item_type       item,
   output div_req_type        div_req,
   input  wire div_rsp_type   div_rsp
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_DIV_Q   = 3'b010,
      ST_DIV_LIM = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] seq_ff,   seq_in;
   logic [31:0] ts_ff,    ts_in;
   logic [12:0] fill_ff,  fill_in;
   logic [12:0] limit_ff, limit_in;
   logic [31:0] ssrc_ff,  ssrc_in;

   logic [9:0]  ms_clamped;
   logic [12:0] fill_inc;
   logic        closing;
   logic        ms_write;

   assign ms_write = csr_we && (csr_index == CSR_PAYLOAD_TIME);

   always_comb begin
      if (csr_wdata[9:0] < MS_MIN) begin
         ms_clamped = MS_MIN;
      end else if (csr_wdata[9:0] > MS_MAX) begin
         ms_clamped = MS_MAX;
      end else begin
         ms_clamped = csr_wdata[9:0];
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !queue_full;
   assign push      = req.valid && req.ready;

   assign fill_inc = fill_ff + 13'd1;
   assign closing  = req.final_byte || (fill_inc >= limit_ff);

   always_comb begin
      item.sample_byte = req.sample_byte;
      item.closing     = closing;
      item.opens       = (fill_ff == '0);
      item.seq         = seq_ff;
      item.ts          = ts_ff;
      item.ssrc        = ssrc_ff;
   end

   // limit = 8000 / (1000 / ms), two passes through the divider
   always_comb begin
      state_in         = state_ff;
      limit_in         = limit_ff;
      div_req.start    = 1'b0;
      div_req.dividend = MS_PER_SEC;
      div_req.divisor  = ms_clamped;

      if (ms_write) begin
         div_req.start = 1'b1;
         state_in      = ST_DIV_Q;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_DIV_Q: begin
               if (div_rsp.done) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = SAMPLES_PER_SEC;
                  div_req.divisor  = div_rsp.quotient[9:0];
                  state_in         = ST_DIV_LIM;
               end
            end
            ST_DIV_LIM: begin
               if (div_rsp.done) begin
                  limit_in = div_rsp.quotient;
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      seq_in  = seq_ff;
      ts_in   = ts_ff;
      fill_in = fill_ff;
      ssrc_in = ssrc_ff;
      if (csr_we && (csr_index == CSR_SSRC)) begin
         ssrc_in = csr_wdata;
      end
      if (push) begin
         if (closing) begin
            seq_in  = seq_ff + 16'd1;
            ts_in   = ts_ff + {19'b0, fill_inc};
            fill_in = '0;
         end else begin
            fill_in = fill_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seq_ff   <= SEQ_RESET;
         ts_ff    <= '0;
         fill_ff  <= '0;
         limit_ff <= LIMIT_RESET;
         ssrc_ff  <= SSRC_RESET;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
         ts_ff    <= ts_in;
         fill_ff  <= fill_in;
         limit_ff <= limit_in;
         ssrc_ff  <= ssrc_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rtpp_queue.sv =====
// ----------------------------------------------------------------------------
// rtpp_queue
// Two-entry queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpp_queue
   import rtpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire pkt_item_type push_item,
   input  wire logic         pop,
   output logic              full,
   output logic              not_empty,
   output pkt_item_type      head
);

   pkt_item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/rtpp_back.sv =====
// ----------------------------------------------------------------------------
// rtpp_back
// Serializes each queued byte: twelve header bytes when it opens a packet,
// then the audio byte, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpp_back
   import rtpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         not_empty,
   input  wire pkt_item_type head,
   output logic              pop,
   rtpp_rsp_if.source        rsp
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;
   logic       end_ff,   end_in;
   logic [3:0] idx_ff,   idx_in;

   logic       load;
   logic       emit_data;
   logic [7:0] hdr_byte;

   assign emit_data = !head.opens || (idx_ff == DATA_IDX);
   assign load      = not_empty && (!valid_ff || rsp.ready);
   assign pop       = load && emit_data;

   always_comb begin
      case (idx_ff)
         4'd0:    hdr_byte = HDR_VERSION_BYTE;
         4'd1:    hdr_byte = HDR_PTYPE_BYTE;
         4'd2:    hdr_byte = head.seq[15:8];
         4'd3:    hdr_byte = head.seq[7:0];
         4'd4:    hdr_byte = head.ts[31:24];
         4'd5:    hdr_byte = head.ts[23:16];
         4'd6:    hdr_byte = head.ts[15:8];
         4'd7:    hdr_byte = head.ts[7:0];
         4'd8:    hdr_byte = head.ssrc[31:24];
         4'd9:    hdr_byte = head.ssrc[23:16];
         4'd10:   hdr_byte = head.ssrc[15:8];
         4'd11:   hdr_byte = head.ssrc[7:0];
         default: hdr_byte = head.sample_byte;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = emit_data ? head.sample_byte : hdr_byte;
         end_in   = emit_data && head.closing;
         idx_in   = emit_data ? 4'd0 : idx_ff + 4'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.packet_byte = byte_ff;
   assign rsp.packet_end  = end_ff;

endmodule

`default_nettype wire

// ===== src/rtpp_checker.sv =====
// ----------------------------------------------------------------------------
// rtpp_checker
// Port-level checks of the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpp_checker
   import rtpp_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_packet_byte,
   input wire logic       rsp_packet_end,
   input wire logic       csr_we,
   input wire logic [0:0] csr_index
);

   // a stalled transfer keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_packet_byte) && $stable(rsp_packet_end))
      else $error("rsp payload changed while stalled");

   // the limit recompute blocks new audio bytes
   assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_PAYLOAD_TIME) |=> !req_ready)
      else $error("req accepted during limit recompute");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind rtp_pcmu_packetizer rtpp_checker u_rtpp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_packet_byte (rsp.packet_byte),
   .rsp_packet_end  (rsp.packet_end),
   .csr_we          (csr_we),
   .csr_index       (csr_index)
);

`default_nettype wire

// ===== tb/rtp_pcmu_packetizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pcmu_packetizer_test
// Drives mu-law bytes through the packetizer with random gaps on both sides,
// predicts every header and payload byte and checks them in order.
// ----------------------------------------------------------------------------

module rtp_pcmu_packetizer_test
   import rtpp_pkg::*;
();

   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] sample;
      logic       last;
   } audio_item_type;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       pkt_end;
   } packet_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = CSR_PAYLOAD_TIME;
   logic [31:0] csr_wdata = '0;

   rtpp_req_if req_ch ();
   rtpp_rsp_if rsp_ch ();

   rtp_pcmu_packetizer dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // packetizer state as the testbench sees it
   logic [15:0] seq_num   = SEQ_RESET;
   logic [31:0] media_ts  = '0;
   logic [12:0] fill_cnt  = '0;
   logic [12:0] pay_limit = LIMIT_RESET;
   logic [31:0] ssrc_id   = SSRC_RESET;

   audio_item_type  pending_audio[$];
   packet_byte_type expected_bytes[$];

   // bit patterns for the eight-byte packet
   logic [7:0] sel_bytes[8] = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h01, 8'hFE};

   int  errors = 0;
   int  accepted_items = 0;
   bit  idling_on = 1'b1;
   bit  long_hold_done = 1'b0;

   function automatic logic [12:0] limit_for_ms(logic [9:0] ms);
      int m;
      m = ms;
      if (m < 1) m = 1;
      if (m > 1000) m = 1000;
      return 13'(8000 / (1000 / m));
   endfunction

   // header on the first byte of a packet, then the byte itself
   function automatic void frame_sample(logic [7:0] sample, logic last);
      logic [95:0] header;
      logic        closing;
      if (fill_cnt == 0) begin
         header = {HDR_VERSION_BYTE, HDR_PTYPE_BYTE, seq_num, media_ts, ssrc_id};
         for (int k = 0; k < 12; k++)
            expected_bytes.insert(expected_bytes.size(), '{header[95 - 8 * k -: 8], 1'b0});
      end
      fill_cnt = fill_cnt + 13'd1;
      closing = last || (fill_cnt >= pay_limit);
      expected_bytes.insert(expected_bytes.size(), '{sample, closing});
      if (closing) begin
         seq_num  = seq_num + 16'd1;
         media_ts = media_ts + {19'd0, fill_cnt};
         fill_cnt = '0;
      end
   endfunction

   task automatic queue_audio(logic [7:0] sample, logic last);
      pending_audio.insert(pending_audio.size(), '{sample, last});
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PAYLOAD_TIME)
         pay_limit = limit_for_ms(value[9:0]);
      else
         ssrc_id = value;
   endtask

   task automatic wait_idle();
      while (pending_audio.size() != 0 || req_ch.valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      int             send_gap;
      audio_item_type item;
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.sample_byte <= '0;
         req_ch.final_byte  <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            frame_sample(req_ch.sample_byte, req_ch.final_byte);
            accepted_items++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 16) - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_audio.size() != 0) begin
               item = pending_audio.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.sample_byte <= item.sample;
               req_ch.final_byte  <= item.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      int              hold_left;
      packet_byte_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected packet byte %02h end %0b", $time,
                        rsp_ch.packet_byte, rsp_ch.packet_end);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.packet_byte !== want.pkt_byte) begin
                  $display("%0t: packet_byte expected %02h actual %02h", $time,
                           want.pkt_byte, rsp_ch.packet_byte);
                  errors++;
               end
               if (rsp_ch.packet_end !== want.pkt_end) begin
                  $display("%0t: packet_end expected %0b actual %0b", $time,
                           want.pkt_end, rsp_ch.packet_end);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!long_hold_done && accepted_items >= 60) begin
            // long back-pressure so the input side fills and stalls
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 16) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || csr_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [31:0] wdata;
      int          sel;
      int          n;
      bit          long_pkts;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: a two-byte packet closed by the final mark, then one alone
      queue_audio(8'h00, 1'b0);
      queue_audio(8'hFF, 1'b1);
      queue_audio(8'hA5, 1'b1);
      wait_idle();

      // duration zero acts as 1 ms, a packet closed by filling
      write_reg(CSR_SSRC, 32'hFFFF_FFFF);
      write_reg(CSR_PAYLOAD_TIME, 32'd0);
      foreach (sel_bytes[i]) queue_audio(sel_bytes[i], 1'b0);
      wait_idle();

      // duration over range, then limit dropped below the fill of the open packet
      write_reg(CSR_PAYLOAD_TIME, 32'd1023);
      for (int i = 0; i < 10; i++) queue_audio(8'($urandom), 1'b0);
      wait_idle();
      write_reg(CSR_SSRC, 32'h0000_0000);
      write_reg(CSR_PAYLOAD_TIME, 32'd1);
      queue_audio(8'h3C, 1'b0);
      queue_audio(8'hC3, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         sel = $urandom_range(0, 9);
         wdata = $urandom;
         long_pkts = 1'b0;
         if (sel == 0) begin
            wdata[9:0] = 10'd0;
         end else if (sel == 1) begin
            wdata[9:0] = 10'($urandom_range(1000, 1023));
            long_pkts = 1'b1;
         end else begin
            wdata[9:0] = 10'($urandom_range(1, 6));
         end
         write_reg(CSR_PAYLOAD_TIME, wdata);
         if ($urandom_range(0, 1) == 1) write_reg(CSR_SSRC, $urandom);
         idling_on = (phase < 7) && ($urandom_range(0, 3) != 0);
         n = $urandom_range(35, 50);
         for (int i = 0; i < n; i++) begin
            if (long_pkts)
               queue_audio(8'($urandom), $urandom_range(0, 19) == 0);
            else
               queue_audio(8'($urandom), $urandom_range(0, 15) == 0);
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
